// ----- hw/rtl/sms_pkg.sv -----
package sms_pkg;

   // Default store geometry
   localparam int MAX_ROWS_DEF = 16;
   localparam int MAX_COLS_DEF = 16;

   // Payload widths
   localparam int VALUE_W   = 32;
   localparam int IDX_W     = 4;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 2'd1;

   // Reset values of the registers
   localparam logic [CFG_W-1:0] ROWS_RESET = 5'd16;
   localparam logic [CFG_W-1:0] COLS_RESET = 5'd16;

   // Operation codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

// ----- hw/rtl/sms_ram.sv -----
module sms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sorted_matrix_staircase_search.sv -----
// Staircase search over a matrix whose rows and columns are sorted ascending.
// A write beat (req_func = 0) stores req_value at (req_row_index,
// req_col_index) in a single-port-write, registered-read RAM; writes outside
// MAX_ROWS x MAX_COLS are dropped. A search beat (req_func = 1) walks from the
// top-right corner of the region set by rows_in_use / cols_in_use (register
// 0 / 1, clamped to the store size), stepping left when the cell is above the
// target and down when below, and returns one rsp_found beat. The walk uses one
// signed comparator against the RAM read port, one cell per cycle: a search
// passes through accept, first read, one compare per visited cell and result
// load. An empty region answers not found. req_ready is low while a search is
// in flight; a finished result sits in its own output register, so new beats
// are taken while it waits for rsp_ready. The CSR port is always ready; it is
// to be written only while no search is in progress, which the user must
// ensure, as the block does not enforce it. Cells never written hold no
// defined value; a search must only visit written cells.
module sorted_matrix_staircase_search #(
   parameter int MAX_ROWS = sms_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = sms_pkg::MAX_COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [sms_pkg::IDX_W-1:0]           req_row_index,
   input  logic [sms_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [sms_pkg::VALUE_W-1:0]  req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sms_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sms_pkg::CFG_W-1:0]           csr_wdata
);

   import sms_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RCW   = $clog2(MAX_ROWS + 1);   // holds 0..MAX_ROWS
   localparam int CCW   = $clog2(MAX_COLS + 1);   // holds 0..MAX_COLS

   // configuration
   logic [CFG_W-1:0] rows_cfg_ff;
   logic [CFG_W-1:0] cols_cfg_ff;

   // sequencer and walk position
   state_type           state_ff, state_in;
   logic [RCW-1:0]      nrows_ff, nrows_in;
   logic [RCW-1:0]      row_ff, row_in;
   logic [CCW-1:0]      col_ff, col_in;      // column plus one, zero = left the region
   logic [AW-1:0]       addr_ff, addr_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic                found_ff, found_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;

   // region clamped to the store
   logic [RCW-1:0] rows_eff;
   logic [CCW-1:0] cols_eff;

   // store ports
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic signed [VALUE_W-1:0] cell_val;

   // walk step results
   logic           hit, go_left, leave;
   logic [RCW-1:0] row_nx;
   logic [CCW-1:0] col_nx;
   logic [AW-1:0]  addr_nx;

   logic req_acc, rsp_acc, slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid_ff && rsp_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign rows_eff = (int'(rows_cfg_ff) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_cfg_ff);
   assign cols_eff = (int'(cols_cfg_ff) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_cfg_ff);

   // ---------------------------------------------------------------- store
   assign wr_en   = req_acc && (req_func == FUNC_WRITE)
                    && (int'(req_row_index) < MAX_ROWS) && (int'(req_col_index) < MAX_COLS);
   assign wr_addr = AW'(int'(req_row_index) * MAX_COLS + int'(req_col_index));

   // In the walk the next address goes straight to the RAM so a cell is
   // compared every cycle; in LOAD the start address is issued.
   assign rd_addr = (state_ff == ST_WALK) ? addr_nx : addr_ff;

   sms_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign cell_val = $signed(rd_data);

   // ---------------------------------------------------------------- one walk step
   always_comb begin
      hit     = (cell_val == target_ff);
      go_left = (cell_val > target_ff);
      row_nx  = row_ff;
      col_nx  = col_ff;
      addr_nx = addr_ff;
      if (go_left) begin
         col_nx  = col_ff - CCW'(1);
         addr_nx = addr_ff - AW'(1);
         leave   = (col_nx == '0);
      end else begin
         row_nx  = row_ff + RCW'(1);
         addr_nx = addr_ff + AW'(MAX_COLS);
         leave   = (row_nx == nrows_ff);
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      nrows_in     = nrows_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      addr_in      = addr_ff;
      target_in    = target_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;

      if (rsp_acc) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_func == FUNC_SEARCH)) begin
               target_in = req_value;
               nrows_in  = rows_eff;
               row_in    = '0;
               col_in    = cols_eff;
               addr_in   = AW'(int'(cols_eff) - 1);
               found_in  = 1'b0;
               if ((rows_eff == '0) || (cols_eff == '0)) begin
                  state_in = ST_DONE;   // empty region
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (hit) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               row_in  = row_nx;
               col_in  = col_nx;
               addr_in = addr_nx;
               if (leave) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_cfg_ff  <= ROWS_RESET;
         cols_cfg_ff  <= COLS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ROWS_IN_USE: rows_cfg_ff <= csr_wdata;
               CSR_COLS_IN_USE: cols_cfg_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      nrows_ff     <= nrows_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      addr_ff      <= addr_in;
      target_ff    <= target_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
   end

   // ---------------------------------------------------------------- checks
   a_walk_in_region: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((col_ff != '0) && (row_ff < nrows_ff)))
      else $error("walk position outside region");

   a_walk_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |->
         (int'(addr_ff) == int'(row_ff) * MAX_COLS + int'(col_ff) - 1))
      else $error("walk address does not match row and column");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_func == FUNC_SEARCH)) |=> !req_ready)
      else $error("search accepted but block still ready");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && slot_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished search did not load the result");

endmodule
